@@ sv/crcam_pkg.sv @@
// ----------------------------------------------------------------------------
// crcam_pkg
// Shared types, constants and helper functions for the constant register CAM.
// ----------------------------------------------------------------------------
package crcam_pkg;

  // Table geometry.
  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths.
  localparam int FUNC_W  = 2;
  localparam int VAL_W   = 64;
  localparam int REG_W   = 8;
  localparam int FLOOR_W = 9;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INV    = 2'd2;

  // IEEE double masks.
  localparam logic [VAL_W-1:0] ABS_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] EXP_MASK = 64'h7FF0_0000_0000_0000;
  localparam logic [VAL_W-1:0] MAN_MASK = 64'h000F_FFFF_FFFF_FFFF;

  // One classified operation, as it waits in the queue.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [VAL_W-1:0]  key_value;
    logic [REG_W-1:0]  reg_num;
    logic              key_nan;
    logic              key_zero;
  } item_t;

  // A value is a NaN when its exponent is all ones and its mantissa is nonzero.
  function automatic logic is_nan(input logic [VAL_W-1:0] v);
    return ((v & EXP_MASK) == EXP_MASK) && ((v & MAN_MASK) != '0);
  endfunction

  // Plus and minus zero both count as zero.
  function automatic logic is_zero(input logic [VAL_W-1:0] v);
    return (v & ABS_MASK) == '0;
  endfunction

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] v);
    logic [IDX_W-1:0] idx;
    logic             found;
    idx   = '0;
    found = 1'b0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (v[k] && !found) begin
        idx   = IDX_W'(k);
        found = 1'b1;
      end
    end
    return idx;
  endfunction

endpackage

@@ sv/constant_register_cam_top.sv @@
// ----------------------------------------------------------------------------
// constant_register_cam_top
// Sixteen-entry associative table from double constants to register numbers.
// ----------------------------------------------------------------------------
// Each input transaction yields exactly one result transaction. A front stage
// classifies the key and writes a two-deep queue; the back executes from the
// queue head against a flip-flop table with a parallel comparator per entry.
// Lookup, add and the unused code sustain one transaction per cycle while the
// result register is free and no invalidate is in progress; the queue and the
// result register lie between an input and its result. An invalidate holds
// the back in a compaction loop that moves one entry per cycle, once for each
// entry that holds the register, through the table's single read port and
// then reports. Results wait in an output register, so new transactions keep
// entering the queue, until it is full, while a result is stalled.
// ----------------------------------------------------------------------------
module constant_register_cam_top import crcam_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [VAL_W-1:0]   in_key_value,
  input  logic [REG_W-1:0]   in_reg_num,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [REG_W-1:0]   out_found_reg,
  output logic               out_accepted,
  output logic [CNT_W-1:0]   out_entry_count,
  output logic [FLOOR_W-1:0] out_floor
);

  logic  q_full;
  logic  q_push;
  item_t q_push_item;
  logic  q_pop;
  logic  q_head_valid;
  item_t q_head_item;

  // Input side: accept and classify.
  crcam_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_key_value (in_key_value),
    .in_reg_num   (in_reg_num),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_push_item)
  );

  // Decoupling queue.
  crcam_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  // Table and execution.
  crcam_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_head_valid),
    .q_item          (q_head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_found_reg   (out_found_reg),
    .out_accepted    (out_accepted),
    .out_entry_count (out_entry_count),
    .out_floor       (out_floor)
  );

endmodule

@@ sv/crcam_front.sv @@
// ----------------------------------------------------------------------------
// crcam_front
// Accepts input transactions, classifies the key and pushes them to the queue.
// ----------------------------------------------------------------------------
module crcam_front import crcam_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [VAL_W-1:0]    in_key_value,
  input  logic [REG_W-1:0]    in_reg_num,
  input  logic                q_full,
  output logic                q_push,
  output item_t               q_item
);

  // The queue pushes back on the input side when it is full.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the key once here so the back only compares.
  always_comb begin
    q_item.func      = in_func;
    q_item.key_value = in_key_value;
    q_item.reg_num   = in_reg_num;
    q_item.key_nan   = is_nan(in_key_value);
    q_item.key_zero  = is_zero(in_key_value);
  end

endmodule

@@ sv/crcam_queue.sv @@
// ----------------------------------------------------------------------------
// crcam_queue
// Short FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module crcam_queue import crcam_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_pop;

  assign full       = count_r == (QPTR_W + 1)'(QDEPTH);
  assign head_valid = count_r != '0;
  assign head_item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Pointer and occupancy updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage is written only on push.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ sv/crcam_back.sv @@
// ----------------------------------------------------------------------------
// crcam_back
// Holds the table, executes lookup, add and invalidate, and registers results.
// ----------------------------------------------------------------------------
module crcam_back import crcam_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [REG_W-1:0]   out_found_reg,
  output logic               out_accepted,
  output logic [CNT_W-1:0]   out_entry_count,
  output logic [FLOOR_W-1:0] out_floor
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_INV  = 1'b1;

  // Table storage and status.
  logic [VAL_W-1:0]   vals_r [ENTRIES];
  logic [REG_W-1:0]   regs_r [ENTRIES];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FLOOR_W-1:0] floor_r, floor_nxt;
  logic               state_r, state_nxt;
  logic [REG_W-1:0]   inv_reg_r, inv_reg_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [REG_W-1:0]   out_found_r, out_found_nxt;
  logic               out_acc_r, out_acc_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic [FLOOR_W-1:0] out_floor_r, out_floor_nxt;

  logic [ENTRIES-1:0] look_match;
  logic [ENTRIES-1:0] inv_match;
  logic [IDX_W-1:0]   rd_idx;
  logic [VAL_W-1:0]   rd_val;
  logic [REG_W-1:0]   rd_reg;
  logic [CNT_W-1:0]   last_cnt;
  logic               out_free;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [VAL_W-1:0]   wr_val;
  logic [REG_W-1:0]   wr_reg;

  assign out_free = !out_valid_r || !out_stall;
  assign last_cnt = cnt_r - 1'b1;

  // Parallel compare of every entry against the head key and the invalidate register.
  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      look_match[k] = (CNT_W'(k) < cnt_r) && !q_item.key_nan && !is_nan(vals_r[k]) &&
                      ((q_item.key_zero && is_zero(vals_r[k])) ||
                       (vals_r[k] == q_item.key_value));
      inv_match[k]  = (CNT_W'(k) < cnt_r) && (regs_r[k] == inv_reg_r);
    end
  end

  // Single read port: the first lookup hit, or the last entry while compacting.
  assign rd_idx = (state_r == ST_INV) ? last_cnt[IDX_W-1:0] : first_set(look_match);
  assign rd_val = vals_r[rd_idx];
  assign rd_reg = regs_r[rd_idx];

  // Sequencer and result selection.
  always_comb begin
    state_nxt     = state_r;
    inv_reg_nxt   = inv_reg_r;
    cnt_nxt       = cnt_r;
    floor_nxt     = floor_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_idx        = cnt_r[IDX_W-1:0];
    wr_val        = q_item.key_value;
    wr_reg        = q_item.reg_num;
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt   = out_hit_r;
    out_found_nxt = out_found_r;
    out_acc_nxt   = out_acc_r;
    out_cnt_nxt   = out_cnt_r;
    out_floor_nxt = out_floor_r;

    case (state_r)
      ST_IDLE: begin
        if (q_valid && q_item.func == FUNC_INV) begin
          // Start compaction; the result follows once no entry matches.
          q_pop       = 1'b1;
          inv_reg_nxt = q_item.reg_num;
          state_nxt   = ST_INV;
        end else if (q_valid && out_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          out_found_nxt = '0;
          out_acc_nxt   = 1'b0;
          out_cnt_nxt   = cnt_r;
          out_floor_nxt = floor_r;
          case (q_item.func)
            FUNC_LOOKUP: begin
              out_hit_nxt   = |look_match;
              out_found_nxt = (|look_match) ? rd_reg : '0;
            end
            FUNC_ADD: begin
              if (cnt_r < CNT_W'(ENTRIES)) begin
                wr_en       = 1'b1;
                cnt_nxt     = cnt_r + 1'b1;
                out_acc_nxt = 1'b1;
                out_cnt_nxt = cnt_r + 1'b1;
                if (floor_r <= {1'b0, q_item.reg_num}) begin
                  floor_nxt     = {1'b0, q_item.reg_num} + 1'b1;
                  out_floor_nxt = {1'b0, q_item.reg_num} + 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_INV: begin
        if (|inv_match) begin
          // Move the last entry into the first matching slot and check it again.
          wr_en   = 1'b1;
          wr_idx  = first_set(inv_match);
          wr_val  = rd_val;
          wr_reg  = rd_reg;
          cnt_nxt = last_cnt;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          out_found_nxt = '0;
          out_acc_nxt   = 1'b0;
          out_cnt_nxt   = cnt_r;
          out_floor_nxt = floor_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      floor_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      floor_r     <= floor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    inv_reg_r   <= inv_reg_nxt;
    out_hit_r   <= out_hit_nxt;
    out_found_r <= out_found_nxt;
    out_acc_r   <= out_acc_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_floor_r <= out_floor_nxt;
  end

  // Table write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vals_r[wr_idx] <= wr_val;
      regs_r[wr_idx] <= wr_reg;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_found_reg   = out_found_r;
  assign out_accepted    = out_acc_r;
  assign out_entry_count = out_cnt_r;
  assign out_floor       = out_floor_r;

endmodule
